[hw/rtl/smf_pkg.sv]
package smf_pkg;

  // age of a sample in the window, wide enough for windows of up to 64 samples
  localparam int unsigned AGE_W = 6;
  localparam int unsigned SAMPLE_W = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0] age_t;

  // one slot of the sorted chain: a sample and how many requests ago it came
  typedef struct packed {
    sample_t value;
    age_t    age;
  } entry_t;

  // what a cell shows its neighbors
  typedef struct packed {
    entry_t entry;
    logic   gt;     // stored value is above the incoming sample
  } link_t;

endpackage

[hw/rtl/smf_cell.sv]
module smf_cell #(
  parameter int unsigned WINDOW = 25,
  parameter int unsigned INDEX  = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  smf_pkg::sample_t sample,
  input  smf_pkg::link_t  below,
  input  smf_pkg::link_t  above,
  input  logic            evict_below,
  output smf_pkg::link_t  link,
  output logic            evict,
  output smf_pkg::entry_t entry_next
);

  localparam smf_pkg::age_t LastAge = smf_pkg::age_t'(WINDOW - 1);
  localparam smf_pkg::age_t ResetAge = smf_pkg::age_t'(INDEX);

  smf_pkg::entry_t entry;
  smf_pkg::entry_t own_aged;
  smf_pkg::entry_t below_aged;
  smf_pkg::entry_t above_aged;
  smf_pkg::entry_t fresh;
  logic            gt;

  assign gt    = entry.value > sample;
  assign evict = entry.age == LastAge;
  assign link  = '{entry: entry, gt: gt};

  assign own_aged   = '{value: entry.value, age: entry.age + 1'b1};
  assign below_aged = '{value: below.entry.value, age: below.entry.age + 1'b1};
  assign above_aged = '{value: above.entry.value, age: above.entry.age + 1'b1};
  assign fresh      = '{value: sample, age: '0};

  always_comb begin
    if ((evict_below || evict) && !above.gt) begin
      // hole at or below: pull down the upper neighbor, still not above the sample
      entry_next = above_aged;
    end else if (evict) begin
      entry_next = below.gt ? below_aged : fresh;
    end else if (evict_below) begin
      entry_next = gt ? own_aged : fresh;
    end else begin
      // hole above: larger values move up one slot
      entry_next = !gt ? own_aged : (below.gt ? below_aged : fresh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '{value: '0, age: ResetAge};
    end else if (load) begin
      entry <= entry_next;
    end
  end

endmodule

[hw/rtl/sliding_window_median_filter_core.sv]
// channel  | direction | handshake                      | payload
// sample   | in        | sample_valid / sample_stall    | sample[7:0]
// median   | out       | median_valid / median_stall    | median[7:0]
//
// one request is taken per cycle while sample_stall is low; its median shows in the
// output register in the next cycle, set by one update of the sorted cell chain per request
// rst is synchronous: window reads all zero, cells hold ages 0..WINDOW-1
// sample_stall is high only while a median waits and median_stall is high
// each cell compares, evicts and inserts in the same cycle as its neighbors
module sliding_window_median_filter_core #(
  parameter int unsigned WINDOW = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  logic [7:0] sample,
  output logic       median_valid,
  input  logic       median_stall,
  output logic [7:0] median
);

  localparam int unsigned Mid = WINDOW / 2;

  logic                  accept;
  logic [WINDOW-1:0]     evict_vec;
  logic [WINDOW-1:0]     evict_below;
  logic [WINDOW-2:0]     order_ok;
  smf_pkg::link_t        links [WINDOW];
  smf_pkg::entry_t       nexts [WINDOW];

  // a new request is taken unless a median is still waiting downstream
  assign sample_stall = median_valid && median_stall;
  assign accept       = sample_valid && !sample_stall;

  // boundary neighbors: nothing below is ever above the sample,
  // nothing above the top cell can be pulled down
  localparam smf_pkg::link_t LowEnd  = '{entry: '0, gt: 1'b0};
  localparam smf_pkg::link_t HighEnd = '{entry: '0, gt: 1'b1};

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      localparam logic [WINDOW-1:0] LowMask = {WINDOW{1'b1}} >> (WINDOW - i);

      // the oldest sample sits in some lower slot
      assign evict_below[i] = |(evict_vec & LowMask);

      smf_cell #(
        .WINDOW (WINDOW),
        .INDEX  (i)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .load        (accept),
        .sample      (sample),
        .below       ((i == 0) ? LowEnd : links[(i == 0) ? 0 : i - 1]),
        .above       ((i == WINDOW - 1) ? HighEnd
                                        : links[(i == WINDOW - 1) ? i : i + 1]),
        .evict_below (evict_below[i]),
        .link        (links[i]),
        .evict       (evict_vec[i]),
        .entry_next  (nexts[i])
      );

      if (i < WINDOW - 1) begin : g_order
        assign order_ok[i] = links[i].entry.value <= links[i + 1].entry.value;
      end
    end
  endgenerate

  // output register: the middle slot of the updated chain
  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (accept) begin
      median_valid <= 1'b1;
    end else if (!median_stall) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median <= nexts[Mid].value;
    end
  end

  // exactly one slot holds the oldest sample
  a_one_oldest : assert property (@(posedge clk) disable iff (rst)
    $onehot(evict_vec))
    else $error("evict flags not one-hot");

  // the chain stays sorted ascending
  a_sorted : assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("cell chain out of order");

  // a taken request shows its median in the next cycle
  a_result : assert property (@(posedge clk) disable iff (rst)
    accept |=> median_valid && median == $past(nexts[Mid].value))
    else $error("median missing after request");

endmodule
